/* src/ler_pkg.sv */
`default_nettype none
package ler_pkg;

  localparam int MaxEventsDefault = 2048;
  localparam int MaxOutDefault    = 64;

  // input kind codes
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_ON     = 3'd1;
  localparam logic [2:0] KIND_SLIDE  = 3'd2;
  localparam logic [2:0] KIND_OFF    = 3'd3;
  localparam logic [2:0] KIND_RECORD = 3'd4;
  localparam logic [2:0] KIND_PLAY   = 3'd5;
  localparam logic [2:0] KIND_CLEAR  = 3'd6;

  // result event codes
  localparam logic [2:0] EV_STATUS = 3'd0;
  localparam logic [2:0] EV_ON     = 3'd1;
  localparam logic [2:0] EV_PITCH  = 3'd2;
  localparam logic [2:0] EV_OFF    = 3'd3;
  localparam logic [2:0] EV_CLICK  = 3'd4;

  // stored event kinds
  localparam logic [1:0] SK_ON    = 2'd1;
  localparam logic [1:0] SK_PITCH = 2'd2;
  localparam logic [1:0] SK_OFF   = 2'd3;

  localparam int EvWidth  = 38;  // pos17, pitch15, kind2, vel4
  localparam int ResWidth = 23;  // kind3, pitch15, vel4, accent1

  // register indexes
  localparam logic [1:0] REG_COUNT_IN = 2'd0;
  localparam logic [1:0] REG_BPB      = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;
  localparam logic [1:0] REG_THRESH   = 2'd3;

  typedef enum logic [1:0] {
    T_STOP  = 2'd0,
    T_COUNT = 2'd1,
    T_REC   = 2'd2,
    T_PLAY  = 2'd3
  } transport_t;

  typedef enum logic [2:0] {
    OP_TICK, OP_ON, OP_SLIDE, OP_OFF, OP_RECORD, OP_PLAY, OP_CLEAR, OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [10:0] delta;
    logic [14:0] pitch;
    logic [3:0]  vel;
  } cmd_t;

  // saturated configuration
  typedef struct packed {
    logic [4:0] count_in;
    logic [4:0] bpb;
    logic [6:0] limit;
    logic [7:0] thresh;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MOD, S_POST, S_FINISH, S_SCAN, S_DRAIN_RD, S_SHOW
  } back_state_t;

endpackage
`default_nettype wire

/* src/ler_ram.sv */
`default_nettype none
module ler_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/ler_front.sv */
`default_nettype none
module ler_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [2:0]    kind,
  input  wire logic [10:0]   beat_delta,
  input  wire logic [14:0]   pitch,
  input  wire logic [3:0]    velocity,
  output logic               cmd_valid,
  output ler_pkg::cmd_t      cmd,
  input  wire logic          cmd_pop
);

  ler_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  ler_pkg::cmd_t in_cmd;
  logic          do_push;

  // decode kind, treat oversize tick advances as zero
  always_comb begin
    case (kind)
      ler_pkg::KIND_TICK:   in_cmd.op = ler_pkg::OP_TICK;
      ler_pkg::KIND_ON:     in_cmd.op = ler_pkg::OP_ON;
      ler_pkg::KIND_SLIDE:  in_cmd.op = ler_pkg::OP_SLIDE;
      ler_pkg::KIND_OFF:    in_cmd.op = ler_pkg::OP_OFF;
      ler_pkg::KIND_RECORD: in_cmd.op = ler_pkg::OP_RECORD;
      ler_pkg::KIND_PLAY:   in_cmd.op = ler_pkg::OP_PLAY;
      ler_pkg::KIND_CLEAR:  in_cmd.op = ler_pkg::OP_CLEAR;
      default:              in_cmd.op = ler_pkg::OP_NOP;
    endcase
    in_cmd.delta = (beat_delta > 11'd1024) ? 11'd0 : beat_delta;
    in_cmd.pitch = pitch;
    in_cmd.vel   = velocity;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, cmd_pop};
    end
  end

endmodule
`default_nettype wire

/* src/ler_back.sv */
`default_nettype none
module ler_back #(
  parameter int MAX_EVENTS = ler_pkg::MaxEventsDefault,
  parameter int MAX_OUT    = ler_pkg::MaxOutDefault,
  localparam int CW  = $clog2(MAX_EVENTS + 1),
  localparam int AW  = $clog2(MAX_EVENTS),
  localparam int RNW = $clog2(MAX_OUT + 1),
  localparam int RAW = $clog2(MAX_OUT)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ler_pkg::cfg_t cfg,
  input  wire logic          cmd_valid,
  input  wire ler_pkg::cmd_t cmd_in,
  output logic               cmd_pop,
  output logic               empty,
  input  wire logic          pop,
  output logic [2:0]         event_kind,
  output logic [14:0]        out_pitch,
  output logic [3:0]         out_velocity,
  output logic               accent,
  output logic [1:0]         transport_state,
  output logic [CW-1:0]      stored_events,
  output logic               overflow,
  output logic               last
);

  ler_pkg::back_state_t state, state_next;
  ler_pkg::cmd_t        cmd;
  ler_pkg::transport_t  mode;

  logic signed [17:0] position, prev, newpos, np;
  logic        [CW-1:0] ev_cnt, scan_i;
  logic        [16:0] loop_len, fin_len;
  logic        [14:0] last_pitch;
  logic               live, rep, incz, inc, wrap, scan_v, over;
  logic        [RNW-1:0] res_n;
  logic        [RAW-1:0] drain_i;
  logic signed [7:0]  mod_v, fb_new, fb_prev, bpb_s;
  logic signed [18:0] fin_acc;
  logic        [14:0] unit, half;

  // memories
  logic                        ev_we;
  logic [AW-1:0]               ev_waddr, ev_raddr;
  logic [ler_pkg::EvWidth-1:0] ev_wdata, ev_rdata;
  logic                        res_we;
  logic [ler_pkg::ResWidth-1:0] res_wdata, res_rdata;

  // result emission
  logic        emit_v;
  logic [2:0]  emit_kind;
  logic [14:0] emit_pitch;
  logic [3:0]  emit_vel;
  logic        emit_acc;

  // decoded stored event
  logic signed [17:0] ep;
  logic        [14:0] e_pitch;
  logic        [1:0]  e_kind;
  logic        [3:0]  e_vel;
  logic               after, hit;
  logic        [14:0] pdiff;
  logic               can_store, rec_now, at_limit, scan_done;

  ler_ram #(.WIDTH(ler_pkg::EvWidth), .DEPTH(MAX_EVENTS)) u_ev_ram (
    .clk(clk), .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
    .raddr(ev_raddr), .rdata(ev_rdata)
  );

  ler_ram #(.WIDTH(ler_pkg::ResWidth), .DEPTH(MAX_OUT)) u_res_ram (
    .clk(clk), .we(res_we), .waddr(res_n[RAW-1:0]), .wdata(res_wdata),
    .raddr(drain_i), .rdata(res_rdata)
  );

  assign unit    = {cfg.bpb, 10'd0};
  assign half    = {1'b0, cfg.bpb, 9'd0};
  assign bpb_s   = $signed({3'd0, cfg.bpb});
  assign newpos  = position + $signed({7'd0, cmd.delta});
  assign fb_new  = newpos[17:10];
  assign fb_prev = position[17:10];
  assign np      = wrap ? position - $signed({1'b0, loop_len}) : position;

  assign ep      = $signed({1'b0, ev_rdata[37:21]});
  assign e_pitch = ev_rdata[20:6];
  assign e_kind  = ev_rdata[5:4];
  assign e_vel   = ev_rdata[3:0];
  assign after   = inc ? (ep >= prev) : (ep > prev);
  assign hit     = wrap ? ((after && (ep < $signed({1'b0, loop_len}))) || (ep <= np))
                        : (after && (ep <= position));

  assign pdiff     = (cmd.pitch > last_pitch) ? cmd.pitch - last_pitch
                                              : last_pitch - cmd.pitch;
  assign can_store = (mode == ler_pkg::T_REC) && !position[17]
                     && (ev_cnt < CW'(MAX_EVENTS));
  assign rec_now   = (mode == ler_pkg::T_REC) || ((mode == ler_pkg::T_COUNT) && !position[17]);
  assign at_limit  = position >= $signed({1'b0, cfg.limit, 10'd0});
  assign scan_done = (scan_i == ev_cnt) && !scan_v;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ler_pkg::S_IDLE: begin
        if (cmd_valid) state_next = ler_pkg::S_EXEC;
      end
      ler_pkg::S_EXEC: begin
        case (cmd.op)
          ler_pkg::OP_TICK: begin
            if (mode == ler_pkg::T_COUNT || mode == ler_pkg::T_REC) begin
              state_next = (fb_new > fb_prev) ? ler_pkg::S_MOD : ler_pkg::S_POST;
            end else if (mode == ler_pkg::T_PLAY && loop_len != 17'd0) begin
              state_next = ler_pkg::S_SCAN;
            end else begin
              state_next = ler_pkg::S_DRAIN_RD;
            end
          end
          ler_pkg::OP_RECORD: begin
            state_next = (mode == ler_pkg::T_REC || mode == ler_pkg::T_COUNT)
                         ? ler_pkg::S_FINISH : ler_pkg::S_DRAIN_RD;
          end
          default: state_next = ler_pkg::S_DRAIN_RD;
        endcase
      end
      ler_pkg::S_MOD: begin
        if (mod_v >= 8'sd0 && mod_v < bpb_s) state_next = ler_pkg::S_POST;
      end
      ler_pkg::S_POST: begin
        state_next = (rec_now && at_limit) ? ler_pkg::S_FINISH : ler_pkg::S_DRAIN_RD;
      end
      ler_pkg::S_FINISH: begin
        if (fin_acc < $signed({4'd0, unit})) state_next = ler_pkg::S_DRAIN_RD;
      end
      ler_pkg::S_SCAN: begin
        if (scan_done) state_next = ler_pkg::S_DRAIN_RD;
      end
      ler_pkg::S_DRAIN_RD: state_next = ler_pkg::S_SHOW;
      ler_pkg::S_SHOW: begin
        if (pop) state_next = last ? ler_pkg::S_IDLE : ler_pkg::S_DRAIN_RD;
      end
      default: state_next = ler_pkg::S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    cmd_pop    = (state == ler_pkg::S_IDLE) && cmd_valid;
    empty      = (state != ler_pkg::S_SHOW);
    emit_v     = 1'b0;
    emit_kind  = ler_pkg::EV_STATUS;
    emit_pitch = 15'd0;
    emit_vel   = 4'd0;
    emit_acc   = 1'b0;
    ev_we      = 1'b0;
    ev_waddr   = ev_cnt[AW-1:0];
    ev_wdata   = {position[16:0], cmd.pitch, ler_pkg::SK_ON, cmd.vel};
    ev_raddr   = scan_i[AW-1:0];
    case (state)
      ler_pkg::S_EXEC: begin
        case (cmd.op)
          ler_pkg::OP_ON: begin
            ev_we = can_store;
          end
          ler_pkg::OP_SLIDE: begin
            ev_we    = can_store && live && ({7'd0, pdiff} > {14'd0, cfg.thresh});
            ev_wdata = {position[16:0], cmd.pitch, ler_pkg::SK_PITCH, 4'd0};
          end
          ler_pkg::OP_OFF: begin
            ev_we    = can_store && live;
            ev_wdata = {position[16:0], 15'd0, ler_pkg::SK_OFF, 4'd0};
          end
          default: ;
        endcase
      end
      ler_pkg::S_MOD: begin
        if (mod_v >= 8'sd0 && mod_v < bpb_s) begin
          emit_v    = 1'b1;
          emit_kind = ler_pkg::EV_CLICK;
          emit_acc  = (mod_v == 8'sd0);
        end
      end
      ler_pkg::S_SCAN: begin
        if (scan_v && hit) begin
          case (e_kind)
            ler_pkg::SK_ON: begin
              emit_v     = 1'b1;
              emit_kind  = ler_pkg::EV_ON;
              emit_pitch = e_pitch;
              emit_vel   = e_vel;
            end
            ler_pkg::SK_PITCH: begin
              emit_v     = rep;
              emit_kind  = ler_pkg::EV_PITCH;
              emit_pitch = e_pitch;
            end
            default: begin
              emit_v    = rep;
              emit_kind = ler_pkg::EV_OFF;
            end
          endcase
        end
      end
      default: ;
    endcase
    res_we    = emit_v && (res_n < RNW'(MAX_OUT));
    res_wdata = {emit_kind, emit_pitch, emit_vel, emit_acc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ler_pkg::S_IDLE;
      mode       <= ler_pkg::T_STOP;
      position   <= 18'sd0;
      ev_cnt     <= '0;
      loop_len   <= 17'd0;
      last_pitch <= 15'd0;
      live       <= 1'b0;
      rep        <= 1'b0;
      incz       <= 1'b0;
      res_n      <= '0;
      over       <= 1'b0;
      drain_i    <= '0;
      scan_v     <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_v) begin
        if (res_n < RNW'(MAX_OUT)) res_n <= res_n + 1'b1;
        else over <= 1'b1;
      end
      if (ev_we) ev_cnt <= ev_cnt + 1'b1;
      case (state)
        ler_pkg::S_IDLE: begin
          cmd     <= cmd_in;
          res_n   <= '0;
          over    <= 1'b0;
          drain_i <= '0;
        end
        ler_pkg::S_EXEC: begin
          case (cmd.op)
            ler_pkg::OP_TICK: begin
              if (mode != ler_pkg::T_STOP) begin
                position <= newpos;
                prev     <= position;
              end
              mod_v   <= fb_new;
              wrap    <= newpos >= $signed({1'b0, loop_len});
              inc     <= incz;
              scan_i  <= '0;
              scan_v  <= 1'b0;
              if (mode == ler_pkg::T_PLAY && loop_len != 17'd0) incz <= 1'b0;
            end
            ler_pkg::OP_ON: begin
              live       <= 1'b1;
              last_pitch <= cmd.pitch;
            end
            ler_pkg::OP_SLIDE: begin
              if (live && ({7'd0, pdiff} > {14'd0, cfg.thresh})) last_pitch <= cmd.pitch;
            end
            ler_pkg::OP_OFF: begin
              live <= 1'b0;
            end
            ler_pkg::OP_RECORD: begin
              fin_acc <= {position[17], position} + $signed({4'd0, half});
              fin_len <= 17'd0;
              if (!(mode == ler_pkg::T_REC || mode == ler_pkg::T_COUNT)) begin
                rep      <= 1'b0;
                ev_cnt   <= '0;
                loop_len <= 17'd0;
                mode     <= ler_pkg::T_COUNT;
                position <= -$signed({3'd0, cfg.count_in, 10'd0});
                incz     <= 1'b0;
              end
            end
            ler_pkg::OP_PLAY: begin
              if (mode != ler_pkg::T_STOP) begin
                mode <= ler_pkg::T_STOP;
                rep  <= 1'b0;
                incz <= 1'b0;
              end else if (loop_len != 17'd0) begin
                mode     <= ler_pkg::T_PLAY;
                position <= 18'sd0;
                incz     <= 1'b1;
              end
            end
            ler_pkg::OP_CLEAR: begin
              ev_cnt   <= '0;
              loop_len <= 17'd0;
              mode     <= ler_pkg::T_STOP;
              position <= 18'sd0;
              rep      <= 1'b0;
              incz     <= 1'b0;
            end
            default: ;
          endcase
        end
        ler_pkg::S_MOD: begin
          if (mod_v < 8'sd0) mod_v <= mod_v + bpb_s;
          else if (mod_v >= bpb_s) mod_v <= mod_v - bpb_s;
        end
        ler_pkg::S_POST: begin
          if (rec_now) mode <= ler_pkg::T_REC;
          fin_acc <= {position[17], position} + $signed({4'd0, half});
          fin_len <= 17'd0;
        end
        ler_pkg::S_FINISH: begin
          if (fin_acc >= $signed({4'd0, unit})) begin
            fin_acc <= fin_acc - $signed({4'd0, unit});
            fin_len <= fin_len + {2'd0, unit};
          end else begin
            loop_len <= (fin_len == 17'd0) ? {2'd0, unit} : fin_len;
            mode     <= ler_pkg::T_STOP;
            position <= 18'sd0;
            incz     <= 1'b0;
            live     <= 1'b0;
          end
        end
        ler_pkg::S_SCAN: begin
          if (scan_i < ev_cnt) begin
            scan_i <= scan_i + 1'b1;
            scan_v <= 1'b1;
          end else begin
            scan_v <= 1'b0;
          end
          if (scan_v && hit) begin
            if (e_kind == ler_pkg::SK_ON) rep <= 1'b1;
            else if (e_kind != ler_pkg::SK_PITCH) rep <= 1'b0;
          end
          if (scan_done) position <= np;
        end
        ler_pkg::S_SHOW: begin
          if (pop && !last) drain_i <= drain_i + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (res_n == '0) begin
      event_kind   = ler_pkg::EV_STATUS;
      out_pitch    = 15'd0;
      out_velocity = 4'd0;
      accent       = 1'b0;
      last         = 1'b1;
    end else begin
      event_kind   = res_rdata[22:20];
      out_pitch    = res_rdata[19:5];
      out_velocity = res_rdata[4:1];
      accent       = res_rdata[0];
      last         = ({1'b0, drain_i} == RNW'(res_n - 1'b1));
    end
  end

  assign transport_state = mode;
  assign stored_events   = ev_cnt;
  assign overflow        = over;

endmodule
`default_nettype wire

/* src/loop_event_recorder.sv */
`default_nettype none
// Loop event recorder. Input side is a queue (push/full) of live gestures,
// transport buttons and timing ticks; the result side is a queue (empty/pop)
// of replayed notes, metronome clicks and status results, each carrying the
// transport state, stored event count and overflow flag after its input, and
// "last" on the final result of that input. A two-entry command queue in
// front decodes items, so pushes are taken while the engine works or waits
// on pop. In play, a tick walks the event memory at one read per cycle.
// Clicks find the beat within the bar by repeated add or subtract of the
// bar length, and stopping a take snaps the loop length to whole bars by
// subtracting one bar at a time. Each result is read from the result
// memory (S_DRAIN_RD) and then shown (S_SHOW) until pop. Replay results
// are capped at MAX_OUT per tick (overflow set). Config writes belong to
// idle periods only.
module loop_event_recorder #(
  parameter int MAX_EVENTS = ler_pkg::MaxEventsDefault,
  parameter int MAX_OUT    = ler_pkg::MaxOutDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input queue side
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [2:0]                        kind,
  input  wire logic [10:0]                       beat_delta,
  input  wire logic [14:0]                       pitch,
  input  wire logic [3:0]                        velocity,
  // result queue side
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [2:0]                             event_kind,
  output logic [14:0]                            out_pitch,
  output logic [3:0]                             out_velocity,
  output logic                                   accent,
  output logic [1:0]                             transport_state,
  output logic [$clog2(MAX_EVENTS+1)-1:0]        stored_events,
  output logic                                   overflow,
  output logic                                   last,
  // config write port
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [7:0]                        cfg_data
);

  logic [4:0] count_in_beats;
  logic [4:0] bar_beats;
  logic [6:0] record_limit_beats;
  logic [7:0] slide_threshold;

  ler_pkg::cfg_t cfg;
  ler_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  // raw registers; zero acts as one, tops clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      count_in_beats     <= 5'd4;
      bar_beats          <= 5'd4;
      record_limit_beats <= 7'd64;
      slide_threshold    <= 8'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        ler_pkg::REG_COUNT_IN: count_in_beats     <= cfg_data[4:0];
        ler_pkg::REG_BPB:      bar_beats          <= cfg_data[4:0];
        ler_pkg::REG_LIMIT:    record_limit_beats <= cfg_data[6:0];
        ler_pkg::REG_THRESH:   slide_threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.count_in = (count_in_beats == 5'd0) ? 5'd1 :
                   (count_in_beats > 5'd16) ? 5'd16 : count_in_beats;
    cfg.bpb      = (bar_beats == 5'd0) ? 5'd1 :
                   (bar_beats > 5'd16) ? 5'd16 : bar_beats;
    cfg.limit    = (record_limit_beats == 7'd0) ? 7'd1 :
                   (record_limit_beats > 7'd64) ? 7'd64 : record_limit_beats;
    cfg.thresh   = slide_threshold;
  end

  ler_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .kind(kind), .beat_delta(beat_delta), .pitch(pitch), .velocity(velocity),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  ler_back #(.MAX_EVENTS(MAX_EVENTS), .MAX_OUT(MAX_OUT)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .cmd_valid(cmd_valid), .cmd_in(cmd), .cmd_pop(cmd_pop),
    .empty(empty), .pop(pop),
    .event_kind(event_kind), .out_pitch(out_pitch), .out_velocity(out_velocity),
    .accent(accent), .transport_state(transport_state),
    .stored_events(stored_events), .overflow(overflow), .last(last)
  );

  // event count never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_events <= ($clog2(MAX_EVENTS+1))'(MAX_EVENTS))
    else $error("stored event count beyond store size");

  // clicks only come from count-in or record ticks
  a_click_mode: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_kind == ler_pkg::EV_CLICK) |-> transport_state != ler_pkg::T_PLAY)
    else $error("click while playing");

  // a status result stands alone
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_kind == ler_pkg::EV_STATUS) |-> last)
    else $error("status result not last");

  // after a transfer of a non-final result, the output is empty or the input queue is not full
  a_drain_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> !full || empty)
    else $error("drain sequencing broken");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import ler_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [2:0] kind = '0;
  logic [10:0] beat_delta = '0;
  logic [14:0] pitch = '0;
  logic [3:0] velocity = '0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] event_kind;
  logic [14:0] out_pitch;
  logic [3:0] out_velocity;
  logic accent;
  logic [1:0] transport_state;
  logic [11:0] stored_events;
  logic overflow;
  logic last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  always #2 clk = ~clk;

  loop_event_recorder dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .kind(kind), .beat_delta(beat_delta),
    .pitch(pitch), .velocity(velocity),
    .empty(empty), .pop(pop), .event_kind(event_kind), .out_pitch(out_pitch),
    .out_velocity(out_velocity), .accent(accent), .transport_state(transport_state),
    .stored_events(stored_events), .overflow(overflow), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int StoreDepth = 2048;
  localparam int ResultCap  = 64;
  localparam int Unit       = 1024;

  typedef struct {
    logic [2:0]  ev;
    logic [14:0] p;
    logic [3:0]  v;
    logic        acc;
    logic [1:0]  ts;
    logic [11:0] cnt;
    logic        ovf;
    logic        lst;
  } result_t;

  typedef struct {
    logic [2:0]  ev;
    logic [14:0] p;
    logic [3:0]  v;
    logic        acc;
  } note_t;

  result_t pending_results[$];
  int errors = 0;

  // ---------------------------------------------------------------------------
  // Transport model: own copy of registers, store and playhead
  // ---------------------------------------------------------------------------
  logic [4:0] r_count_in = 5'd4;
  logic [4:0] r_bpb      = 5'd4;
  logic [6:0] r_limit    = 7'd64;
  logic [7:0] r_thresh   = 8'd12;

  logic [16:0] take_pos   [StoreDepth];
  logic [14:0] take_pitch [StoreDepth];
  logic [1:0]  take_kind  [StoreDepth];
  logic [3:0]  take_vel   [StoreDepth];

  int          take_len = 0;    // events stored
  int          loop_len = 0;    // loop length in 1/1024 beat
  transport_t  mode = T_STOP;
  int          head = 0;        // playhead, negative in count-in
  int          slide_ref = 0;   // last pitch seen by the slide filter
  bit          live_on = 0, replay_on = 0, first_tick = 0;

  note_t       tick_notes[$];
  bit          tick_dropped;

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void add_note(logic [2:0] ev, logic [14:0] p, logic [3:0] v, logic a);
    note_t n;
    if (tick_notes.size() < ResultCap) begin
      n.ev = ev; n.p = p; n.v = v; n.acc = a;
      tick_notes.push_back(n);
    end else begin
      tick_dropped = 1;
    end
  endfunction

  function automatic void record_event(logic [1:0] sk, logic [14:0] p, logic [3:0] v);
    if (mode == T_REC && head >= 0 && take_len < StoreDepth) begin
      take_pos[take_len]   = head[16:0];
      take_pitch[take_len] = p;
      take_kind[take_len]  = sk;
      take_vel[take_len]   = v;
      take_len++;
    end
  endfunction

  function automatic int beat_of(int p);
    return p >= 0 ? p / Unit : -((-p + Unit - 1) / Unit);
  endfunction

  // snap the take to whole bars and stop
  function automatic void close_take();
    int bar_len, bars;
    bar_len = clampi(r_bpb, 1, 16) * Unit;
    bars = head > 0 ? (head + bar_len / 2) / bar_len : 0;
    if (bars < 1) bars = 1;
    loop_len = bars * bar_len;
    mode = T_STOP;
    head = 0;
    first_tick = 0;
    live_on = 0;
  endfunction

  function automatic void replay(int i);
    if (take_kind[i] == SK_ON) begin
      replay_on = 1;
      add_note(EV_ON, take_pitch[i], take_vel[i], 1'b0);
    end else if (take_kind[i] == SK_PITCH) begin
      if (replay_on) add_note(EV_PITCH, take_pitch[i], '0, 1'b0);
    end else if (replay_on) begin
      replay_on = 0;
      add_note(EV_OFF, '0, '0, 1'b0);
    end
  endfunction

  function automatic void advance(logic [10:0] delta);
    int d, prev, fb, bpb, m, np, p;
    bit inc, wrap, after, hit;
    d = delta > Unit ? 0 : int'(delta);
    prev = head;
    if (mode != T_STOP) head += d;
    if (mode == T_COUNT || mode == T_REC) begin
      fb = beat_of(head);
      if (fb > beat_of(prev)) begin
        bpb = clampi(r_bpb, 1, 16);
        m = fb % bpb;
        if (m < 0) m += bpb;
        add_note(EV_CLICK, '0, '0, m == 0);
      end
    end
    if (mode == T_COUNT && head >= 0) mode = T_REC;
    if (mode == T_REC && head >= clampi(r_limit, 1, 64) * Unit) close_take();
    if (mode == T_PLAY && loop_len > 0) begin
      inc = first_tick;
      wrap = head >= loop_len;
      np = wrap ? head - loop_len : head;
      first_tick = 0;
      for (int i = 0; i < take_len; i++) begin
        p = int'(take_pos[i]);
        after = inc ? p >= prev : p > prev;
        hit = wrap ? ((after && p < loop_len) || p <= np) : (after && p <= head);
        if (hit) replay(i);
      end
      head = np;
    end
  endfunction

  // one accepted item: update the model and queue what the block must return
  function automatic void predict_item(logic [2:0] k, logic [10:0] d, logic [14:0] p,
                                       logic [3:0] v);
    int diff;
    result_t r;
    tick_notes.delete();
    tick_dropped = 0;
    case (k)
      KIND_TICK: advance(d);
      KIND_ON: begin
        live_on = 1;
        record_event(SK_ON, p, v);
        slide_ref = p;
      end
      KIND_SLIDE: begin
        if (live_on) begin
          diff = p > slide_ref ? p - slide_ref : slide_ref - p;
          if (diff > r_thresh) begin
            record_event(SK_PITCH, p, '0);
            slide_ref = p;
          end
        end
      end
      KIND_OFF: begin
        if (live_on) begin
          live_on = 0;
          record_event(SK_OFF, '0, '0);
        end
      end
      KIND_RECORD: begin
        if (mode == T_REC || mode == T_COUNT) begin
          close_take();
        end else begin
          replay_on = 0;
          take_len = 0;
          loop_len = 0;
          mode = T_COUNT;
          head = -clampi(r_count_in, 1, 16) * Unit;
          first_tick = 0;
        end
      end
      KIND_PLAY: begin
        if (mode != T_STOP) begin
          mode = T_STOP;
          replay_on = 0;
          first_tick = 0;
        end else if (loop_len > 0) begin
          mode = T_PLAY;
          head = 0;
          first_tick = 1;
        end
      end
      KIND_CLEAR: begin
        take_len = 0;
        loop_len = 0;
        mode = T_STOP;
        head = 0;
        replay_on = 0;
        first_tick = 0;
      end
      default: ;
    endcase
    if (tick_notes.size() == 0) add_note(EV_STATUS, '0, '0, 1'b0);
    foreach (tick_notes[i]) begin
      r.ev = tick_notes[i].ev; r.p = tick_notes[i].p;
      r.v = tick_notes[i].v; r.acc = tick_notes[i].acc;
      r.ts = mode; r.cnt = take_len[11:0]; r.ovf = tick_dropped;
      r.lst = (i == tick_notes.size() - 1);
      pending_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  int pop_cycle = 0;
  int pop_style = 0;

  // style is redrawn at random: always ready, mostly ready, mostly stalled
  always @(negedge clk) begin
    pop_cycle <= pop_cycle + 1;
    if (pop_cycle % 300 == 0) pop_style = $urandom_range(0, 2);
    case (pop_style)
      0: pop = 1'b1;
      1: pop = ($urandom_range(0, 3) != 0);
      default: pop = ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && !empty && pop) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: event_kind %0d", event_kind);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (event_kind !== e.ev) begin
          $error("event_kind: expected %0d, got %0d", e.ev, event_kind); errors++;
        end
        if (out_pitch !== e.p) begin
          $error("out_pitch: expected %0d, got %0d", e.p, out_pitch); errors++;
        end
        if (out_velocity !== e.v) begin
          $error("out_velocity: expected %0d, got %0d", e.v, out_velocity); errors++;
        end
        if (accent !== e.acc) begin
          $error("accent: expected %0d, got %0d", e.acc, accent); errors++;
        end
        if (transport_state !== e.ts) begin
          $error("transport_state: expected %0d, got %0d", e.ts, transport_state); errors++;
        end
        if (stored_events !== e.cnt) begin
          $error("stored_events: expected %0d, got %0d", e.cnt, stored_events); errors++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow: expected %0d, got %0d", e.ovf, overflow); errors++;
        end
        if (last !== e.lst) begin
          $error("last: expected %0d, got %0d", e.lst, last); errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // drive one item from a falling edge; returns on a falling edge after transfer and any random gap.
  // a typed item replaces the predicted status result with the one given here
  task automatic send(logic [2:0] k, logic [10:0] d, logic [14:0] p, logic [3:0] v,
                      bit typed = 0, logic [1:0] ts = '0, logic [11:0] cnt = '0);
    result_t r;
    push = 1'b1;
    kind = k; beat_delta = d; pitch = p; velocity = v;
    do @(posedge clk); while (full);
    predict_item(k, d, p, v);
    if (typed) begin
      r.ev = EV_STATUS; r.p = '0; r.v = '0; r.acc = 1'b0;
      r.ts = ts; r.cnt = cnt; r.ovf = 1'b0; r.lst = 1'b1;
      pending_results[pending_results.size() - 1] = r;
    end
    @(negedge clk);
    push = 1'b0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      // sometimes back-to-back bursts, sometimes a gap
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 25)) @(negedge clk);
    end
  endtask

  task automatic send_rand(logic [2:0] k);
    send(k, 11'($urandom()), 15'($urandom()), 4'($urandom()));
  endtask

  task automatic tick(logic [10:0] d);
    send(KIND_TICK, d, 15'($urandom()), 4'($urandom()));
  endtask

  // let every expected result drain, then give the engine time to settle
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_COUNT_IN: r_count_in = val[4:0];
      REG_BPB:      r_bpb = val[4:0];
      REG_LIMIT:    r_limit = val[6:0];
      default:      r_thresh = val;
    endcase
  endtask

  task automatic set_regs(logic [7:0] cin, logic [7:0] bpb, logic [7:0] lim,
                          logic [7:0] thr);
    drain();
    write_reg(REG_COUNT_IN, cin);
    write_reg(REG_BPB, bpb);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_THRESH, thr);
  endtask

  function automatic logic [10:0] rand_delta();
    // mostly legal advances, sometimes oversized ones that count as zero
    return ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1025, 2047))
                                       : 11'($urandom_range(0, 1024));
  endfunction

  // a take: count-in, live playing, close or abort, then playback with noise
  task automatic take_and_play();
    int steps, sel;
    send_rand(KIND_RECORD);
    while (mode == T_COUNT) tick(11'($urandom_range(200, 1024)));
    steps = $urandom_range(4, 16);
    for (int i = 0; i < steps && mode == T_REC; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) send_rand(KIND_ON);
      else if (sel < 5)
        send(KIND_SLIDE, 11'($urandom()), 15'(slide_ref + $urandom_range(0, 80) - 40),
             4'($urandom()));
      else if (sel < 7) send_rand(KIND_OFF);
      else tick(rand_delta());
    end
    sel = $urandom_range(0, 9);
    if (mode != T_STOP) begin
      if (sel < 8) send_rand(KIND_RECORD);
      else send_rand(KIND_PLAY);
    end
    send_rand(KIND_PLAY);
    steps = $urandom_range(6, 16);
    for (int i = 0; i < steps; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 16) tick(rand_delta());
      else send_rand(3'($urandom_range(1, 7)));
    end
    if (mode != T_STOP && $urandom_range(0, 1) == 0)
      send_rand(KIND_PLAY);
  endtask

  // directed rows; typed rows carry their single expected status result
  typedef struct {
    logic [2:0]  k;
    logic [10:0] d;
    logic [14:0] p;
    logic [3:0]  v;
    bit          typed;
    logic [1:0]  ts;
    logic [11:0] cnt;
  } row_t;

  row_t dir_rows[$];

  function automatic void row(logic [2:0] k, logic [10:0] d, logic [14:0] p, logic [3:0] v,
                              bit typed = 0, logic [1:0] ts = 0, logic [11:0] cnt = 0);
    row_t r;
    r.k = k; r.d = d; r.p = p; r.v = v; r.typed = typed; r.ts = ts; r.cnt = cnt;
    dir_rows.push_back(r);
  endfunction

  initial begin
    // unknown kind, ticks in stop, buttons with nothing recorded
    row(OP_NOP, 11'd2047, 15'h7fff, 4'hf, 1, T_STOP, 0);
    row(KIND_TICK, 11'd2047, 0, 0, 1, T_STOP, 0);
    row(KIND_PLAY, 0, 0, 0, 1, T_STOP, 0);
    row(KIND_SLIDE, 0, 15'h7fff, 0, 1, T_STOP, 0);
    row(KIND_OFF, 0, 0, 0, 1, T_STOP, 0);
    row(KIND_ON, 0, 15'h7fff, 4'hf, 1, T_STOP, 0);  // live note, not recorded
    row(KIND_OFF, 0, 0, 0, 1, T_STOP, 0);
    row(KIND_RECORD, 0, 0, 0, 1, T_COUNT, 0);
    row(KIND_RECORD, 0, 0, 0, 1, T_STOP, 0);        // stop in count-in: one empty bar
    row(KIND_PLAY, 0, 0, 0, 1, T_PLAY, 0);
    row(KIND_TICK, 11'd1024, 0, 0, 1, T_PLAY, 0);
    row(KIND_PLAY, 0, 0, 0, 1, T_STOP, 0);
    row(KIND_RECORD, 0, 0, 0, 1, T_COUNT, 0);
    for (int i = 0; i < 4; i++) row(KIND_TICK, 11'd1024, 0, 0);  // clicks
    row(KIND_ON, 0, 0, 0);
    row(KIND_SLIDE, 0, 15'd12, 0);                   // at threshold, filtered
    row(KIND_SLIDE, 0, 15'd13, 0);
    row(KIND_TICK, 11'd1025, 0, 0);                  // oversized advance
    row(KIND_TICK, 11'd700, 0, 0);
    row(KIND_OFF, 0, 0, 0);
    row(KIND_ON, 0, 15'h7fff, 4'hf);
    row(KIND_TICK, 11'd1024, 0, 0);
    row(KIND_OFF, 0, 0, 0);
    row(KIND_RECORD, 0, 0, 0);
    row(KIND_PLAY, 0, 0, 0);
    for (int i = 0; i < 6; i++) row(KIND_TICK, 11'd900, 0, 0);
    row(KIND_CLEAR, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_regs(8'd4, 8'd4, 8'd64, 8'd12);
    foreach (dir_rows[i]) begin
      send(dir_rows[i].k, dir_rows[i].d, dir_rows[i].p, dir_rows[i].v,
           dir_rows[i].typed, dir_rows[i].ts, dir_rows[i].cnt);
    end

    // register extremes: zero saturates up to one, all-ones down to the top
    set_regs(8'd0, 8'd0, 8'd0, 8'd0);
    take_and_play();
    set_regs(8'hff, 8'hff, 8'hff, 8'hff);
    take_and_play();
    set_regs(8'd1, 8'd16, 8'd12, 8'd255);
    take_and_play();
    for (int ph = 0; ph < 2; ph++) begin
      set_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 8)),
               8'($urandom_range(2, 14)), 8'($urandom_range(0, 255)));
      take_and_play();
      if ($urandom_range(0, 3) == 0) send_rand(KIND_CLEAR);
    end

    // pile more events than the per-tick cap at one spot, then replay: overflow
    set_regs(8'd1, 8'd1, 8'd64, 8'd0);
    send(KIND_RECORD, 0, 0, 0);
    tick(11'd1024);
    for (int i = 0; i < ResultCap / 2 + 2; i++) begin
      send_rand(KIND_ON);
      send_rand(KIND_OFF);
    end
    send(KIND_RECORD, 0, 0, 0);
    send(KIND_PLAY, 0, 0, 0);
    for (int i = 0; i < 3; i++) tick(11'd1024);
    send(KIND_CLEAR, 0, 0, 0);

    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/ler_pkg.sv
src/ler_ram.sv
src/ler_front.sv
src/ler_back.sv
src/loop_event_recorder.sv
tb/tb_top.sv
